@@ hdl/pcac_pkg.sv @@
package pcac_pkg;

    localparam int COORD_W      = 16;
    localparam int COUNT_W      = 11;
    localparam int MAX_VERTICES = 1024;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SQRT_STEPS   = 19;
    localparam int DIV_STEPS    = 16;
    localparam logic [15:0] SCALE_RESET = 16'd64;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TOO_FEW  = 2'd1;
    localparam logic [1:0] STATUS_TOO_MANY = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t vertex_x;
        coord_t vertex_y;
        logic   last_vertex;
    } vertex_t;

    typedef struct packed {
        logic [10:0] vertex_count;
        logic [1:0]  status;
        logic [31:0] area;
        coord_t      centroid_x;
        coord_t      centroid_y;
        logic [31:0] perimeter;
        coord_t      box_left;
        coord_t      box_top;
        coord_t      box_right;
        coord_t      box_bottom;
        logic [47:0] scaled_perimeter;
        logic [63:0] scaled_area;
    } result_t;

    typedef enum logic [1:0] {
        KIND_FIRST,
        KIND_EDGE,
        KIND_DROP
    } kind_t;

    typedef struct packed {
        coord_t             x;
        coord_t             y;
        kind_t              kind;
        logic               last;
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMD,
        ST_CLOSE,
        ST_PROD,
        ST_DIFF,
        ST_MOMENT,
        ST_ACCUM,
        ST_SQRT,
        ST_LENGTH,
        ST_AREA,
        ST_DIV_SETUP,
        ST_DIV,
        ST_DIV_DONE,
        ST_SCALE1,
        ST_SCALE2,
        ST_EMIT
    } back_state_t;

endpackage

@@ hdl/pcac_queue.sv @@
module pcac_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  pcac_pkg::cmd_t         push_data,
    input  logic                   pop,
    output pcac_pkg::cmd_t         pop_data,
    output pcac_pkg::queue_status_t status
);
    import pcac_pkg::*;

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem[rd_ptr_reg];
    assign status.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);

endmodule

@@ hdl/pcac_front.sv @@
module pcac_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  pcac_pkg::vertex_t       in_data,
    input  pcac_pkg::queue_status_t q_status,
    output logic                    push,
    output pcac_pkg::cmd_t          cmd
);
    import pcac_pkg::*;

    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               ovf_reg, ovf_next;
    logic               at_max;

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;
    assign at_max   = (cnt_reg == COUNT_W'(MAX_VERTICES));

    // classify the vertex against the running count
    always_comb
    begin
        cmd.x        = in_data.vertex_x;
        cmd.y        = in_data.vertex_y;
        cmd.last     = in_data.last_vertex;
        cmd.overflow = ovf_reg || at_max;
        cmd.count    = at_max ? cnt_reg : cnt_reg + 1'b1;
        priority if (at_max)
        begin
            cmd.kind = KIND_DROP;
        end
        else if (cnt_reg == '0)
        begin
            cmd.kind = KIND_FIRST;
        end
        else
        begin
            cmd.kind = KIND_EDGE;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (push)
        begin
            cnt_next = in_data.last_vertex ? '0 : cmd.count;
            ovf_next = in_data.last_vertex ? 1'b0 : cmd.overflow;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

@@ hdl/pcac_back.sv @@
module pcac_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pcac_pkg::queue_status_t q_status,
    input  pcac_pkg::cmd_t          q_data,
    output logic                    pop,
    input  logic [15:0]             scale,
    output logic                    out_valid,
    input  logic                    out_stall,
    output pcac_pkg::result_t       out_data
);
    import pcac_pkg::*;

    back_state_t state_reg, state_next;
    logic        emit_fire;

    cmd_t   cmd_reg;
    coord_t first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    coord_t ax_reg, ay_reg, bx_reg, by_reg;
    coord_t left_reg, top_reg, right_reg, bottom_reg;
    logic   closing_reg;

    logic signed [31:0] p1_reg, p2_reg;
    logic signed [16:0] dx_reg, dy_reg, sx_reg, sy_reg;
    logic signed [32:0] cr_reg;
    logic signed [33:0] dxx_reg, dyy_reg;
    logic signed [49:0] mx_reg, my_reg;

    logic signed [43:0] cross_reg;
    logic signed [61:0] mxs_reg, mys_reg;
    logic [31:0]        len_reg;

    logic [37:0] sq_n_reg, sq_r_reg, sq_bit_reg;
    logic [4:0]  sq_cnt_reg;

    logic [31:0] area_reg;
    logic [45:0] ad_reg;
    logic [63:0] div_rem_reg;
    logic [61:0] div_d_reg;
    logic [15:0] div_q_reg;
    logic [3:0]  div_cnt_reg;
    logic        div_sat_reg, div_neg_reg, div_sel_reg;
    coord_t      cx_reg, cy_reg;
    logic [47:0] per_scaled_reg;
    logic [31:0] scale_sq_reg;
    logic [63:0] area_scaled_reg;

    logic    out_valid_reg;
    result_t out_data_reg;

    // combinational helpers
    logic signed [33:0] d2;
    logic [37:0]        sq_sum;
    logic [32:0]        len_sum;
    logic [43:0]        abs_cross;
    logic [44:0]        half_up;
    logic signed [61:0] m_sel;
    logic [61:0]        abs_m;
    logic [63:0]        div_num;
    logic [46:0]        div_den;
    coord_t             div_val;
    logic [1:0]         status_w;
    logic               sqrt_done, div_done;

    assign d2        = dxx_reg + dyy_reg;
    assign sq_sum    = sq_r_reg + sq_bit_reg;
    assign len_sum   = 33'(len_reg) + 33'(sq_r_reg[18:0])
                       + 33'(sq_n_reg > sq_r_reg);
    assign abs_cross = cross_reg[43] ? 44'(-cross_reg) : 44'(cross_reg);
    assign half_up   = ({1'b0, abs_cross} + 45'd1) >> 1;
    assign m_sel     = div_sel_reg ? mys_reg : mxs_reg;
    assign abs_m     = m_sel[61] ? 62'(-m_sel) : 62'(m_sel);
    assign div_num   = {1'b0, abs_m, 1'b0} + 64'(ad_reg);
    assign div_den   = {ad_reg, 1'b0};
    assign sqrt_done = (sq_cnt_reg == 5'(SQRT_STEPS - 1));
    assign div_done  = (div_cnt_reg == 4'(DIV_STEPS - 1));

    always_comb
    begin
        priority if (div_sat_reg)
        begin
            div_val = div_neg_reg ? 16'sh8000 : 16'sh7FFF;
        end
        else if (div_neg_reg)
        begin
            div_val = (div_q_reg > 16'd32768) ? 16'sh8000 : coord_t'(-div_q_reg);
        end
        else
        begin
            div_val = (div_q_reg > 16'd32767) ? 16'sh7FFF : coord_t'(div_q_reg);
        end
    end

    always_comb
    begin
        priority if (cmd_reg.overflow)
        begin
            status_w = STATUS_TOO_MANY;
        end
        else if (cmd_reg.count < COUNT_W'(3))
        begin
            status_w = STATUS_TOO_FEW;
        end
        else
        begin
            status_w = STATUS_OK;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (!q_status.empty)
                begin
                    state_next = ST_CMD;
                end
            ST_CMD:
                priority if (cmd_reg.kind == KIND_EDGE)
                begin
                    state_next = ST_PROD;
                end
                else if (cmd_reg.last)
                begin
                    state_next = ST_CLOSE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            ST_CLOSE:
                state_next = (status_w == STATUS_OK) ? ST_PROD : ST_EMIT;
            ST_PROD:   state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_MOMENT;
            ST_MOMENT: state_next = ST_ACCUM;
            ST_ACCUM:  state_next = ST_SQRT;
            ST_SQRT:
                if (sqrt_done)
                begin
                    state_next = ST_LENGTH;
                end
            ST_LENGTH:
                priority if (closing_reg)
                begin
                    state_next = ST_AREA;
                end
                else if (cmd_reg.last)
                begin
                    state_next = ST_CLOSE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            ST_AREA:
                state_next = (cross_reg == '0) ? ST_SCALE1 : ST_DIV_SETUP;
            ST_DIV_SETUP: state_next = ST_DIV;
            ST_DIV:
                if (div_done)
                begin
                    state_next = ST_DIV_DONE;
                end
            ST_DIV_DONE:
                state_next = div_sel_reg ? ST_SCALE1 : ST_DIV_SETUP;
            ST_SCALE1: state_next = ST_SCALE2;
            ST_SCALE2: state_next = ST_EMIT;
            ST_EMIT:
                if (emit_fire)
                begin
                    state_next = ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop       = (state_reg == ST_IDLE) && !q_status.empty;
        emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cross_reg     <= '0;
            mxs_reg       <= '0;
            mys_reg       <= '0;
            len_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_MOMENT)
            begin
                cross_reg <= cross_reg + 44'(cr_reg);
            end
            if (state_reg == ST_ACCUM)
            begin
                mxs_reg <= mxs_reg + 62'(mx_reg);
                mys_reg <= mys_reg + 62'(my_reg);
            end
            if (state_reg == ST_LENGTH)
            begin
                len_reg <= (len_sum[32]) ? 32'hFFFF_FFFF : len_sum[31:0];
            end
            // drop the polygon sums once its result is out
            if (emit_fire)
            begin
                cross_reg <= '0;
                mxs_reg   <= '0;
                mys_reg   <= '0;
                len_reg   <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (!q_status.empty)
                begin
                    cmd_reg <= q_data;
                end
            ST_CMD:
                priority if (cmd_reg.kind == KIND_FIRST)
                begin
                    first_x_reg <= cmd_reg.x;
                    first_y_reg <= cmd_reg.y;
                    prev_x_reg  <= cmd_reg.x;
                    prev_y_reg  <= cmd_reg.y;
                    left_reg    <= cmd_reg.x;
                    right_reg   <= cmd_reg.x;
                    top_reg     <= cmd_reg.y;
                    bottom_reg  <= cmd_reg.y;
                end
                else if (cmd_reg.kind == KIND_EDGE)
                begin
                    ax_reg      <= prev_x_reg;
                    ay_reg      <= prev_y_reg;
                    bx_reg      <= cmd_reg.x;
                    by_reg      <= cmd_reg.y;
                    prev_x_reg  <= cmd_reg.x;
                    prev_y_reg  <= cmd_reg.y;
                    closing_reg <= 1'b0;
                    if (cmd_reg.x < left_reg)   left_reg   <= cmd_reg.x;
                    if (cmd_reg.x > right_reg)  right_reg  <= cmd_reg.x;
                    if (cmd_reg.y < top_reg)    top_reg    <= cmd_reg.y;
                    if (cmd_reg.y > bottom_reg) bottom_reg <= cmd_reg.y;
                end
                else
                begin
                    closing_reg <= 1'b0;
                end
            ST_CLOSE:
            begin
                ax_reg      <= prev_x_reg;
                ay_reg      <= prev_y_reg;
                bx_reg      <= first_x_reg;
                by_reg      <= first_y_reg;
                closing_reg <= 1'b1;
                cx_reg      <= '0;
                cy_reg      <= '0;
            end
            ST_PROD:
            begin
                p1_reg <= ax_reg * by_reg;
                p2_reg <= bx_reg * ay_reg;
                dx_reg <= 17'(bx_reg) - 17'(ax_reg);
                dy_reg <= 17'(by_reg) - 17'(ay_reg);
                sx_reg <= 17'(ax_reg) + 17'(bx_reg);
                sy_reg <= 17'(ay_reg) + 17'(by_reg);
            end
            ST_DIFF:
            begin
                cr_reg  <= 33'(p1_reg) - 33'(p2_reg);
                dxx_reg <= 34'(dx_reg) * 34'(dx_reg);
                dyy_reg <= 34'(dy_reg) * 34'(dy_reg);
            end
            ST_MOMENT:
            begin
                mx_reg     <= 50'(sx_reg) * 50'(cr_reg);
                my_reg     <= 50'(sy_reg) * 50'(cr_reg);
                sq_n_reg   <= {d2[33:0], 4'b0};
                sq_r_reg   <= '0;
                sq_bit_reg <= 38'(1) << 36;
                sq_cnt_reg <= '0;
            end
            ST_SQRT:
            begin
                if (sq_n_reg >= sq_sum)
                begin
                    sq_n_reg <= sq_n_reg - sq_sum;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
            end
            ST_AREA:
            begin
                area_reg    <= (half_up[44:32] != '0) ? 32'hFFFF_FFFF : half_up[31:0];
                ad_reg      <= {2'b0, abs_cross} + {1'b0, abs_cross, 1'b0};
                div_sel_reg <= 1'b0;
            end
            ST_DIV_SETUP:
            begin
                div_rem_reg <= div_num;
                div_d_reg   <= {div_den, 15'b0};
                div_sat_reg <= (div_num >= {1'b0, div_den, 16'b0});
                div_neg_reg <= m_sel[61] ^ cross_reg[43];
                div_q_reg   <= '0;
                div_cnt_reg <= '0;
            end
            ST_DIV:
            begin
                if (div_rem_reg >= 64'(div_d_reg))
                begin
                    div_rem_reg <= div_rem_reg - 64'(div_d_reg);
                    div_q_reg   <= {div_q_reg[14:0], 1'b1};
                end
                else
                begin
                    div_q_reg <= {div_q_reg[14:0], 1'b0};
                end
                div_d_reg   <= div_d_reg >> 1;
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            ST_DIV_DONE:
            begin
                if (div_sel_reg)
                begin
                    cy_reg <= div_val;
                end
                else
                begin
                    cx_reg <= div_val;
                end
                div_sel_reg <= 1'b1;
            end
            ST_SCALE1:
            begin
                per_scaled_reg <= 48'(len_reg) * 48'(scale);
                scale_sq_reg   <= 32'(scale) * 32'(scale);
            end
            ST_SCALE2:
                area_scaled_reg <= 64'(area_reg) * 64'(scale_sq_reg);
            ST_EMIT:
                if (emit_fire)
                begin
                    out_data_reg              <= '0;
                    out_data_reg.vertex_count <= cmd_reg.count;
                    out_data_reg.status       <= status_w;
                    if (status_w == STATUS_OK)
                    begin
                        out_data_reg.area             <= area_reg;
                        out_data_reg.centroid_x       <= cx_reg;
                        out_data_reg.centroid_y       <= cy_reg;
                        out_data_reg.perimeter        <= len_reg;
                        out_data_reg.box_left         <= left_reg;
                        out_data_reg.box_top          <= top_reg;
                        out_data_reg.box_right        <= right_reg;
                        out_data_reg.box_bottom       <= bottom_reg;
                        out_data_reg.scaled_perimeter <= per_scaled_reg;
                        out_data_reg.scaled_area      <= area_scaled_reg;
                    end
                end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_ok_needs_three: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.status == STATUS_OK)
        |-> out_data_reg.vertex_count >= COUNT_W'(3))
        else $error("ok result with fewer than three vertices");

    a_too_many_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.status == STATUS_TOO_MANY)
        |-> out_data_reg.vertex_count == COUNT_W'(MAX_VERTICES))
        else $error("overflow result without saturated count");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("emitted result not presented");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == ST_CMD) && $past(state_reg == ST_IDLE))
        else $error("queue popped outside of idle");

endmodule

@@ hdl/polygon_area_centroid_perimeter_unit.sv @@
// Polygon measurement unit: shoelace area, centroid, perimeter, bounding box.
//
// Input channel (in_valid / in_stall / in_data): one vertex per transfer,
// signed Q14.2 coordinates, last_vertex marks the end of a polygon. The
// back end records a first vertex and runs the edge arithmetic on every
// later one, including the 19-step edge length square root. A polygon's
// last vertex then adds the closing edge and the finishing work (two
// centroid divisions, area, the scaling products and the result
// register); the divisions are skipped when the area is zero. Fewer
// than three vertices or more than MAX_VERTICES skip that work and
// emit at once. One vertex is in progress at a time. Output channel
// (out_valid / out_stall / out_data): one result transfer per polygon,
// held in an output register; while the receiver stalls the back end
// holds its finished result and the two-entry queue keeps taking
// vertices until full, then in_stall rises. Configuration (cfg_valid /
// cfg_ready / cfg_data): pixel_scale, always ready; the user must write
// it only while idle, which the block itself does not enforce. Reset
// clears the vertex count, sums, queue and output valid and sets
// pixel_scale to 1.0 (Q10.6).
module polygon_area_centroid_perimeter_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pcac_pkg::vertex_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output pcac_pkg::result_t   out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);
    import pcac_pkg::*;

    logic [15:0]   scale_reg;
    logic          push, pop;
    cmd_t          push_cmd, pop_cmd;
    queue_status_t q_status;

    // hold pixel_scale; cfg_ready is tied high, so every write transfer is accepted when offered
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            scale_reg <= cfg_data;
        end
    end

    // front: count and classify vertices
    pcac_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_status (q_status),
        .push     (push),
        .cmd      (push_cmd)
    );

    // decouple the two halves
    pcac_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .status    (q_status)
    );

    // back: edge arithmetic, finishing and the result register
    pcac_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_data    (pop_cmd),
        .pop       (pop),
        .scale     (scale_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ bench/testbench.sv @@
module testbench;
    import pcac_pkg::*;

    // Scoreboard: follows the polygon as vertices are accepted and holds
    // the expected measurement results in arrival order.
    class polygon_scoreboard;
        logic [15:0]        scale;
        longint             first_x, first_y, prev_x, prev_y;
        longint             cross_acc, mom_x_acc, mom_y_acc;
        longint unsigned    len_acc;
        longint             left, top, right, bottom;
        int                 nverts;
        bit                 overflowed;
        result_t            pending[$];
        int                 mismatches;
        int                 results_seen;

        function new();
            scale = SCALE_RESET;
            mismatches = 0;
            results_seen = 0;
            clear();
        endfunction

        function void clear();
            first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
            cross_acc = 0; mom_x_acc = 0; mom_y_acc = 0; len_acc = 0;
            left = 0; top = 0; right = 0; bottom = 0;
            nverts = 0;
            overflowed = 0;
        endfunction

        // Square root of v, rounded to the nearest integer.
        function longint unsigned round_sqrt(longint unsigned v);
            longint unsigned r, b, n;
            r = 0;
            n = v;
            b = 64'd1 << 62;
            while (b > n)
                b >>= 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            if (v > r * r + r)
                r++;
            return r;
        endfunction

        function void add_edge(longint ax, longint ay, longint bx, longint by);
            longint cr, dx, dy;
            cr = ax * by - bx * ay;
            dx = bx - ax;
            dy = by - ay;
            cross_acc += cr;
            mom_x_acc += (ax + bx) * cr;
            mom_y_acc += (ay + by) * cr;
            len_acc += round_sqrt((dx * dx + dy * dy) << 4);
            if (len_acc > 64'hFFFF_FFFF)
                len_acc = 64'hFFFF_FFFF;
        endfunction

        // Rounded quotient, ties away from zero, saturated to a coordinate.
        function coord_t centroid_quot(longint m, longint d);
            longint unsigned am, ad, q;
            bit neg;
            am = (m < 0) ? -m : m;
            ad = (d < 0) ? -d : d;
            q = (2 * am + ad) / (2 * ad);
            neg = (m < 0) != (d < 0);
            if (neg)
                return (q > 32768) ? -16'sd32768 : coord_t'(-longint'(q));
            return (q > 32767) ? 16'sd32767 : coord_t'(q);
        endfunction

        // Take one accepted vertex; queue a result on the last one.
        function void note_vertex(vertex_t v);
            longint x, y;
            result_t r;
            longint unsigned abs_s, ar, per;
            x = v.vertex_x;
            y = v.vertex_y;
            if (nverts >= MAX_VERTICES)
                overflowed = 1;
            else
            begin
                if (nverts == 0)
                begin
                    first_x = x; first_y = y;
                    left = x; right = x; top = y; bottom = y;
                end
                else
                begin
                    add_edge(prev_x, prev_y, x, y);
                    if (x < left) left = x;
                    if (y < top) top = y;
                    if (x > right) right = x;
                    if (y > bottom) bottom = y;
                end
                prev_x = x;
                prev_y = y;
                nverts++;
            end
            if (!v.last_vertex)
                return;
            r = '0;
            r.vertex_count = 11'(nverts);
            if (overflowed)
                r.status = STATUS_TOO_MANY;
            else if (nverts < 3)
                r.status = STATUS_TOO_FEW;
            else
            begin
                add_edge(prev_x, prev_y, first_x, first_y);
                abs_s = (cross_acc < 0) ? -cross_acc : cross_acc;
                ar = (abs_s + 1) >> 1;
                if (ar > 64'hFFFF_FFFF)
                    ar = 64'hFFFF_FFFF;
                if (cross_acc != 0)
                begin
                    r.centroid_x = centroid_quot(mom_x_acc, 3 * cross_acc);
                    r.centroid_y = centroid_quot(mom_y_acc, 3 * cross_acc);
                end
                per = len_acc;
                r.status = STATUS_OK;
                r.area = 32'(ar);
                r.perimeter = 32'(per);
                r.box_left = 16'(left);
                r.box_top = 16'(top);
                r.box_right = 16'(right);
                r.box_bottom = 16'(bottom);
                r.scaled_perimeter = 48'(per * scale);
                r.scaled_area = ar * (longint'(scale) * scale);
            end
            pending.push_back(r);
            clear();
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch result %0d\n  expected %p\n  actual   %p",
                             results_seen, want, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    vertex_t     in_data;
    logic        out_valid;
    logic        out_stall;
    result_t     out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    polygon_area_centroid_perimeter_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    polygon_scoreboard board;

    // Idle rates in percent, changed per phase.
    int  send_idle_pct;
    int  recv_idle_pct;
    // Set to force a long receiver hold-off.
    bit  hold_receiver;
    int  idle_cycles;
    int  vertices_sent;
    int  polygons_sent;
    bit  timed_out;

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Watchdog: count cycles without any transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000 && !timed_out)
        begin
            timed_out = 1;
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: sample at the rising edge, change stall at the falling edge.
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_data);

    initial
    begin
        out_stall = 1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_receiver)
                out_stall <= 1;
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Send one vertex; hold it steady until the transfer happens. Valid
    // stays up after the transfer until the next vertex or an idle call.
    task automatic send_vertex(int x, int y, int last);
        vertex_t v;
        v.vertex_x = 16'(x);
        v.vertex_y = 16'(y);
        v.last_vertex = (last != 0);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        in_data <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_vertex(v);
        vertices_sent++;
        if (v.last_vertex)
            polygons_sent++;
        @(negedge clk);
    endtask

    // Wait until every queued result has come, then let the back end
    // finish any vertex that produces no result.
    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_scale(logic [15:0] value);
        cfg_valid <= 1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.scale = value;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic logic signed [15:0] rand_coord(int span);
        int unsigned r;
        r = $urandom_range(15);
        if (r == 0)
            return 16'($urandom);
        if (r == 1)
            return ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
        return 16'(int'($urandom_range(2 * span)) - span);
    endfunction

    // Random polygon: n vertices with random coordinates within the span, plus occasional extreme values.
    task automatic send_polygon(int n, int span);
        for (int i = 0; i < n; i++)
            send_vertex(rand_coord(span), rand_coord(span), i == n - 1);
    endtask

    task automatic random_phase(int nverts);
        int target;
        int n;
        target = vertices_sent + nverts;
        while (vertices_sent < target)
        begin
            n = $urandom_range(99);
            if (n < 8)
                n = $urandom_range(2, 1);
            else if (n < 90)
                n = $urandom_range(12, 3);
            else
                n = $urandom_range(40, 13);
            send_polygon(n, (1 << $urandom_range(15, 2)));
        end
    endtask

    initial
    begin
        logic [15:0] scales[5];
        board = new();
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_valid = 0;
        cfg_data = '0;
        hold_receiver = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        idle_cycles = 0;
        vertices_sent = 0;
        polygons_sent = 0;
        timed_out = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: default scale first, square, degenerate and extreme cases.
        send_vertex(0, 0, 0);
        send_vertex(400, 0, 0);
        send_vertex(400, 400, 0);
        send_vertex(0, 400, 1);
        send_vertex(5, 5, 1);                       // single vertex: too few
        send_vertex(1, 2, 0);
        send_vertex(3, 4, 1);                       // two vertices: too few
        send_vertex(1, 1, 0);
        send_vertex(2, 2, 0);
        send_vertex(3, 3, 1);                       // collinear: zero area
        send_vertex(16'sh8000, 16'sh8000, 0);
        send_vertex(16'sh7FFF, 16'sh8000, 0);
        send_vertex(16'sh7FFF, 16'sh7FFF, 0);
        send_vertex(16'sh8000, 16'sh7FFF, 1);       // full-range square
        send_vertex(16'sh7FFF, 16'sh7FFF, 0);
        send_vertex(16'sh8000, 16'sh8000, 0);
        send_vertex(16'sh7FFF, 16'sh8000, 1);       // clockwise, large
        send_vertex(-10, 0, 0);
        send_vertex(0, -10, 0);
        send_vertex(10, 3, 1);
        drain();

        // Too many vertices: overflow past the vertex limit.
        for (int i = 0; i < MAX_VERTICES + 3; i++)
            send_vertex(int'(16'($urandom)), int'(16'($urandom)),
                        i == MAX_VERTICES + 2);
        drain();

        scales = '{16'hFFFF, 16'h0000, 16'd1, 16'd64, 16'h8000};
        for (int s = 0; s < 5; s++)
        begin
            write_scale(scales[s]);
            send_polygon(4, 32767);
            send_polygon(3, 100);
            drain();
        end

        // Random phases: sender rarely idle and receiver mostly stalled, then the reverse.
        write_scale(16'($urandom));
        send_idle_pct = 7;
        recv_idle_pct = 81;
        random_phase(200);
        drain();

        write_scale(16'($urandom));
        send_idle_pct = 81;
        recv_idle_pct = 7;
        random_phase(150);
        drain();

        // Long receiver hold-off while the sender keeps offering vertices.
        write_scale(16'hFFFF);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_receiver = 1;
        fork
            begin
                repeat (600) @(negedge clk);
                hold_receiver = 0;
            end
            begin
                random_phase(60);
                in_valid <= 0;
            end
        join
        drain();

        write_scale(16'h0000);
        random_phase(100);
        drain();

        $display("covered %0d vertices in %0d polygons, %0d results, scales incl. 0 and max",
                 vertices_sent, polygons_sent, board.results_seen);
        if (board.mismatches == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d mismatches in total", board.mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
